// File: rtl/unicode_escape_decoder_defines.svh
// Assertion macros shared by the unicode escape decoder RTL files.
`ifndef UNICODE_ESCAPE_DECODER_DEFINES_SVH
`define UNICODE_ESCAPE_DECODER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define UED_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define UED_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ued_pkg.sv
// Types, character constants and the hex digit decoder of the escape decoder.
package ued_pkg;

    localparam logic [7:0] BACKSLASH_CHAR   = 8'h5C;
    localparam logic [7:0] U_CHAR           = 8'h75;
    localparam logic [7:0] LOWER_HEX_OFFSET = 8'd87;

    // One output word as it sits in the output queue.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_end;
        logic        string_end;
        logic        bad_escape;
    } t_unit;

    typedef struct packed {
        logic       ok;
        logic [3:0] digit;
    } t_hex;

    // A byte that is not a hex digit decodes as zero with ok clear.
    function automatic t_hex hex_value(input logic [7:0] b);
        t_hex r;
        r.ok    = 1'b1;
        r.digit = 4'd0;
        case (b) inside
            [8'h30:8'h39]: r.digit = 4'(b - 8'h30);
            [8'h61:8'h66]: r.digit = 4'(b - LOWER_HEX_OFFSET);
            [8'h41:8'h46]: r.digit = 4'(b - 8'h41 + 8'd10);
            default:       r.ok    = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/ued_if.sv
// Valid/ready channel interfaces for the byte input and the code unit output.
interface ued_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface ued_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        run_end;
    logic        string_end;
    logic        bad_escape;

    modport source (output valid, output code_unit, output run_end, output string_end,
                    output bad_escape, input ready);
    modport sink   (input valid, input code_unit, input run_end, input string_end,
                    input bad_escape, output ready);
endinterface

// File: rtl/unicode_escape_decoder.sv
// Top level of the unicode escape decoder: byte register, escape decode and state.
//
// The decoder takes the bytes of a string value, one byte per cycle, and gives
// 16-bit code units. Plain bytes come out zero-extended; a backslash, 'u' and
// four hex digits (upper or lower case) become one code unit, and a backslash
// followed by any other byte gives the backslash and then that byte, but a
// non-final backslash opens a new escape instead. A digit that is not hex
// counts as zero and sets bad_escape on the escape. When the last byte of a
// string arrives inside an escape, a lone backslash is flushed as is, and a
// partial hex value is flushed with bad_escape set. run_end marks the last word
// caused by an input byte and string_end the last word of the string; a byte
// that opens an escape gives no word. Each byte waits in an input register and
// is decoded into a registered three-word output queue. The output port gives
// one word per cycle while the sink is ready, so a byte that yields two words
// (backslash then a non-'u' byte) holds the port longer; the input holds off
// only when the queue cannot take two more words.
`include "unicode_escape_decoder_defines.svh"

module unicode_escape_decoder (
    input  logic i_clk,
    input  logic i_rst_n,
    ued_in_if.sink    i_in,
    ued_out_if.source o_out
);
    import ued_pkg::*;

    typedef enum logic [2:0] {
        PH_NORMAL = 3'd0,
        PH_BSLASH = 3'd1,
        PH_DIG0   = 3'd2,
        PH_DIG1   = 3'd3,
        PH_DIG2   = 3'd4,
        PH_DIG3   = 3'd5
    } t_phase;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_last;

    // Escape state.
    t_phase      r_phase, n_phase;
    logic [15:0] r_accum, n_accum;
    logic        r_derr,  n_derr;

    logic        w_room;
    logic        w_adv;
    logic        w_head_valid;
    t_unit       w_head;
    logic [1:0]  w_cnt;
    logic [1:0]  w_push_cnt;
    logic [15:0] w_unit0, w_unit1;
    logic        w_bad0;
    t_unit       w_word0, w_word1;
    t_hex        w_hex;
    logic [15:0] w_acc_next;
    logic        w_derr_next;

    // The registered byte moves on whenever the queue can take two words.
    assign w_adv      = r_in_valid && w_room;
    assign i_in.ready = !r_in_valid || w_room;

    assign w_hex       = hex_value(r_byte);
    assign w_acc_next  = {r_accum[11:0], w_hex.digit};
    assign w_derr_next = r_derr || !w_hex.ok;

    always_comb begin
        w_cnt   = 2'd0;
        w_unit0 = 16'd0;
        w_unit1 = 16'd0;
        w_bad0  = 1'b0;
        n_phase = r_phase;
        n_accum = r_accum;
        n_derr  = r_derr;
        case (r_phase)
            PH_BSLASH: begin
                if (r_byte == U_CHAR) begin
                    n_accum = 16'd0;
                    n_derr  = 1'b0;
                    if (r_last) begin
                        w_cnt  = 2'd1;
                        w_bad0 = 1'b1;
                    end else begin
                        n_phase = PH_DIG0;
                    end
                end else begin
                    // The pending backslash goes out, then the byte is seen afresh.
                    w_cnt   = 2'd1;
                    w_unit0 = {8'd0, BACKSLASH_CHAR};
                    n_phase = PH_NORMAL;
                    if (r_byte == BACKSLASH_CHAR && !r_last) begin
                        n_phase = PH_BSLASH;
                    end else begin
                        w_cnt   = 2'd2;
                        w_unit1 = {8'd0, r_byte};
                    end
                end
            end
            PH_DIG0, PH_DIG1, PH_DIG2, PH_DIG3: begin
                n_accum = w_acc_next;
                n_derr  = w_derr_next;
                if (r_phase == PH_DIG3) begin
                    w_cnt   = 2'd1;
                    w_unit0 = w_acc_next;
                    w_bad0  = w_derr_next;
                    n_phase = PH_NORMAL;
                end else if (r_last) begin
                    // Escape cut short by the end of the string.
                    w_cnt   = 2'd1;
                    w_unit0 = w_acc_next;
                    w_bad0  = 1'b1;
                end else begin
                    n_phase = t_phase'(r_phase + 3'd1);
                end
            end
            default: begin
                n_phase = PH_NORMAL;
                if (r_byte == BACKSLASH_CHAR && !r_last) begin
                    n_phase = PH_BSLASH;
                end else begin
                    w_cnt   = 2'd1;
                    w_unit0 = {8'd0, r_byte};
                end
            end
        endcase
        if (r_last) begin
            n_phase = PH_NORMAL;
            n_accum = 16'd0;
            n_derr  = 1'b0;
        end
    end

    always_comb begin
        w_word0.code_unit  = w_unit0;
        w_word0.run_end    = (w_cnt == 2'd1);
        w_word0.string_end = (w_cnt == 2'd1) && r_last;
        w_word0.bad_escape = w_bad0;
        w_word1.code_unit  = w_unit1;
        w_word1.run_end    = 1'b1;
        w_word1.string_end = r_last;
        w_word1.bad_escape = 1'b0;
    end

    assign w_push_cnt = w_adv ? w_cnt : 2'd0;

    ued_oq u_oq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_word0    (w_word0),
        .i_word1    (w_word1),
        .i_pop      (w_head_valid && o_out.ready),
        .o_room     (w_room),
        .o_valid    (w_head_valid),
        .o_head     (w_head)
    );

    assign o_out.valid      = w_head_valid;
    assign o_out.code_unit  = w_head.code_unit;
    assign o_out.run_end    = w_head.run_end;
    assign o_out.string_end = w_head.string_end;
    assign o_out.bad_escape = w_head.bad_escape;

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.byte_in;
            r_last <= i_in.last_byte;
        end
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_NORMAL;
            r_accum    <= 16'd0;
            r_derr     <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (w_adv) begin
                r_phase <= n_phase;
                r_accum <= n_accum;
                r_derr  <= n_derr;
            end
        end
    end

    `UED_ASSERT_NEXT(a_last_clears, w_adv && r_last, r_phase == PH_NORMAL && r_accum == 16'd0 && !r_derr, "state not cleared after the last byte")
    `UED_ASSERT_NOW(a_last_emits, w_adv && r_last, w_cnt != 2'd0, "last byte of a string gave no word")
    `UED_ASSERT_NOW(a_two_words_only_after_bslash, w_cnt == 2'd2, r_phase == PH_BSLASH, "two words outside a pending backslash")

endmodule

// File: rtl/ued_oq.sv
// Three-word output queue that takes up to two words and gives one word per cycle when popped.
`include "unicode_escape_decoder_defines.svh"

module ued_oq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [1:0]     i_push_cnt,
    input  ued_pkg::t_unit i_word0,
    input  ued_pkg::t_unit i_word1,
    input  logic           i_pop,
    output logic           o_room,
    output logic           o_valid,
    output ued_pkg::t_unit o_head
);
    import ued_pkg::*;

    localparam int DEPTH = 3;

    t_unit      r_q [DEPTH];
    t_unit      n_q [DEPTH];
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic [1:0] w_base;

    // Slot where the first new word lands once the head has left.
    assign w_base  = r_count - {1'b0, i_pop};
    assign o_room  = (w_base <= 2'd1);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_q[0];

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            if (i_pop && k < DEPTH - 1) begin
                n_q[k] = r_q[k + 1];
            end else begin
                n_q[k] = r_q[k];
            end
        end
        for (int k = 0; k < DEPTH; k++) begin
            if (i_push_cnt != 2'd0 && w_base == 2'(k)) begin
                n_q[k] = i_word0;
            end
            if (i_push_cnt == 2'd2 && w_base + 2'd1 == 2'(k)) begin
                n_q[k] = i_word1;
            end
        end
        n_count = w_base + i_push_cnt;
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    `UED_ASSERT_NOW(a_no_overflow, i_push_cnt != 2'd0, w_base <= 2'd1 || (i_push_cnt == 2'd1 && w_base == 2'd2), "output queue overflow")
    `UED_ASSERT_NOW(a_pop_nonempty, i_pop, r_count != 2'd0, "pop from empty output queue")
    `UED_ASSERT_NEXT(a_drain, i_pop && i_push_cnt == 2'd0, r_count == $past(r_count) - 2'd1, "queue count did not drop on a pop")

endmodule
